### design/mpbb_pkg.sv
// Shared types and constants for the marked-pixel bounding-box crop block.
// No dependencies; imported by every module of the block.
package mpbb_pkg;

   // Grid size register defaults and limits
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;
   localparam int SIZE_W       = 7;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // Box edge ports and their cleared value
   localparam int EDGE_W = 6;
   localparam logic [EDGE_W-1:0] EDGE_CLEAR = 6'd63;

   // Character width and the marked-cell character
   localparam int CHAR_W = 8;
   localparam logic [CHAR_W-1:0] MARK_CHAR = 8'd42;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 1'd1;

   // Word actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Per-word flags from the tracker to the result register
   typedef struct packed {
      logic read_hit;
      logic row_end;
      logic crop_last;
      logic frame_done;
      logic box_empty;
   } trk_status_type;

endpackage

### design/mpbb_store.sv
// Grid byte store: one write or one read per cycle, registered read data.
// Depends on mpbb_pkg for the character width.
module mpbb_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 addr,
   input  logic [mpbb_pkg::CHAR_W-1:0]   wr_data,
   output logic [mpbb_pkg::CHAR_W-1:0]   rd_data
);
   import mpbb_pkg::*;

   logic [CHAR_W-1:0] mem_ff [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // Write the loaded byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // Read and hold the cropped byte
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mpbb_tracker.sv
// Load and read cursors, bounding-box edges and store address generation.
// Depends on mpbb_pkg for widths, the mark character and the status struct.
module mpbb_tracker #(
   parameter int MAX_ROWS = mpbb_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = mpbb_pkg::DEF_MAX_COLS,
   parameter int AW       = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          action,
   input  logic [mpbb_pkg::CHAR_W-1:0]   cell_char,
   input  logic [mpbb_pkg::SIZE_W-1:0]   grid_rows,
   input  logic [mpbb_pkg::SIZE_W-1:0]   grid_cols,
   output logic                          mem_we,
   output logic                          mem_re,
   output logic [AW-1:0]                 mem_addr,
   output mpbb_pkg::trk_status_type      status,
   output logic [mpbb_pkg::EDGE_W-1:0]   box_top,
   output logic [mpbb_pkg::EDGE_W-1:0]   box_bottom,
   output logic [mpbb_pkg::EDGE_W-1:0]   box_left,
   output logic [mpbb_pkg::EDGE_W-1:0]   box_right
);
   import mpbb_pkg::*;

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int NRW = $clog2(MAX_ROWS + 1);
   localparam int NCW = $clog2(MAX_COLS + 1);
   localparam int SRW = (NRW > SIZE_W) ? NRW : SIZE_W;
   localparam int SCW = (NCW > SIZE_W) ? NCW : SIZE_W;

   logic [RW-1:0] load_row_ff, load_row_in, top_ff, top_in, bottom_ff, bottom_in;
   logic [RW-1:0] rd_row_ff, rd_row_in;
   logic [CW-1:0] load_col_ff, load_col_in, left_ff, left_in, right_ff, right_in;
   logic [CW-1:0] rd_col_ff, rd_col_in;
   logic          loaded_ff, loaded_in, seen_ff, seen_in;

   logic [SRW-1:0] rows_eff;
   logic [SCW-1:0] cols_eff;
   logic [RW-1:0]  cur_row, height_m1, rd_abs_row;
   logic [CW-1:0]  cur_col, width_m1, rd_abs_col;
   logic           cur_seen, is_mark, read_hit, row_end, crop_last;
   logic [AW-1:0]  load_addr, read_addr;

   // Clamp the configured grid size into 1..MAX
   always_comb begin
      if (grid_rows == '0) begin
         rows_eff = SRW'(1);
      end else if (SRW'(grid_rows) > SRW'(MAX_ROWS)) begin
         rows_eff = SRW'(MAX_ROWS);
      end else begin
         rows_eff = SRW'(grid_rows);
      end
      if (grid_cols == '0) begin
         cols_eff = SCW'(1);
      end else if (SCW'(grid_cols) > SCW'(MAX_COLS)) begin
         cols_eff = SCW'(MAX_COLS);
      end else begin
         cols_eff = SCW'(grid_cols);
      end
   end

   // A load after a complete grid starts from a cleared frame
   assign cur_row  = loaded_ff ? '0 : load_row_ff;
   assign cur_col  = loaded_ff ? '0 : load_col_ff;
   assign cur_seen = loaded_ff ? 1'b0 : seen_ff;
   assign is_mark  = (cell_char == MARK_CHAR);

   // Read position inside the box
   assign width_m1   = right_ff - left_ff;
   assign height_m1  = bottom_ff - top_ff;
   assign rd_abs_row = top_ff + rd_row_ff;
   assign rd_abs_col = left_ff + rd_col_ff;
   assign read_hit   = (action == ACT_READ) && loaded_ff && seen_ff;
   assign row_end    = read_hit && (rd_col_ff >= width_m1);
   assign crop_last  = row_end && (rd_row_ff >= height_m1);

   // Store addresses, row major with a fixed row pitch
   assign load_addr = AW'(cur_row) * AW'(MAX_COLS) + AW'(cur_col);
   assign read_addr = AW'(rd_abs_row) * AW'(MAX_COLS) + AW'(rd_abs_col);

   assign mem_we   = step && (action == ACT_LOAD);
   assign mem_re   = step && read_hit;
   assign mem_addr = (action == ACT_LOAD) ? load_addr : read_addr;

   // Next state for one word
   always_comb begin
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      loaded_in   = loaded_ff;
      seen_in     = seen_ff;
      top_in      = top_ff;
      bottom_in   = bottom_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      rd_row_in   = rd_row_ff;
      rd_col_in   = rd_col_ff;
      if (action == ACT_LOAD) begin
         loaded_in = 1'b0;
         seen_in   = cur_seen;
         if (loaded_ff) begin
            top_in    = RW'(EDGE_CLEAR);
            bottom_in = '0;
            left_in   = CW'(EDGE_CLEAR);
            right_in  = '0;
            rd_row_in = '0;
            rd_col_in = '0;
         end
         // Grow the box around a marked cell
         if (is_mark) begin
            seen_in = 1'b1;
            if (!cur_seen) begin
               top_in    = cur_row;
               bottom_in = cur_row;
               left_in   = cur_col;
               right_in  = cur_col;
            end else begin
               if (cur_row < top_ff)    top_in    = cur_row;
               if (cur_row > bottom_ff) bottom_in = cur_row;
               if (cur_col < left_ff)   left_in   = cur_col;
               if (cur_col > right_ff)  right_in  = cur_col;
            end
         end
         // Advance the load cursor
         if (SCW'(cur_col) + SCW'(1) >= cols_eff) begin
            load_col_in = '0;
            if (SRW'(cur_row) + SRW'(1) >= rows_eff) begin
               load_row_in = '0;
               loaded_in   = 1'b1;
            end else begin
               load_row_in = cur_row + RW'(1);
            end
         end else begin
            load_row_in = cur_row;
            load_col_in = cur_col + CW'(1);
         end
      end else if (read_hit) begin
         // Advance the read cursor, wrap at the end of the box
         if (row_end) begin
            rd_col_in = '0;
            rd_row_in = crop_last ? '0 : rd_row_ff + RW'(1);
         end else begin
            rd_col_in = rd_col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff <= '0;
         load_col_ff <= '0;
         loaded_ff   <= 1'b0;
         seen_ff     <= 1'b0;
         top_ff      <= RW'(EDGE_CLEAR);
         bottom_ff   <= '0;
         left_ff     <= CW'(EDGE_CLEAR);
         right_ff    <= '0;
         rd_row_ff   <= '0;
         rd_col_ff   <= '0;
      end else if (step) begin
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         loaded_ff   <= loaded_in;
         seen_ff     <= seen_in;
         top_ff      <= top_in;
         bottom_ff   <= bottom_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
         rd_row_ff   <= rd_row_in;
         rd_col_ff   <= rd_col_in;
      end
   end

   // Flags and edges as they stand after this word
   assign status.read_hit   = read_hit;
   assign status.row_end    = row_end;
   assign status.crop_last  = crop_last;
   assign status.frame_done = loaded_in;
   assign status.box_empty  = !seen_in;

   assign box_top    = seen_in ? EDGE_W'(top_in) : EDGE_CLEAR;
   assign box_bottom = EDGE_W'(bottom_in);
   assign box_left   = seen_in ? EDGE_W'(left_in) : EDGE_CLEAR;
   assign box_right  = EDGE_W'(right_in);

endmodule

### design/marked_pixel_bounding_box_crop_top.sv
// A word's result is registered and shown in the cycle after it is accepted.
// Throughput: one word per cycle while rsp_stall is low; the single result register
// takes a new word in the cycle its current word leaves, so one store access per word
// sets the pace. Reset: cursors, box and flags clear, grid size returns to 64 x 64;
// the grid store is not cleared and holds unknown bytes until loaded.
module marked_pixel_bounding_box_crop_top #(
   parameter int MAX_ROWS = mpbb_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = mpbb_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request words
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [mpbb_pkg::CHAR_W-1:0]     req_cell_char,
   // Response words
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mpbb_pkg::CHAR_W-1:0]     rsp_out_char,
   output logic                            rsp_read_valid,
   output logic                            rsp_row_end,
   output logic                            rsp_crop_last,
   output logic                            rsp_frame_done,
   output logic                            rsp_box_empty,
   output logic [mpbb_pkg::EDGE_W-1:0]     rsp_box_top,
   output logic [mpbb_pkg::EDGE_W-1:0]     rsp_box_bottom,
   output logic [mpbb_pkg::EDGE_W-1:0]     rsp_box_left,
   output logic [mpbb_pkg::EDGE_W-1:0]     rsp_box_right,
   // Register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mpbb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpbb_pkg::SIZE_W-1:0]     csr_wdata
);
   import mpbb_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [SIZE_W-1:0] grid_rows_ff, grid_cols_ff;
   logic              accept, rsp_valid_ff, rsp_valid_in;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_addr;
   logic [CHAR_W-1:0] mem_q;
   trk_status_type    trk_status, status_ff;
   logic [EDGE_W-1:0] top_nx, bottom_nx, left_nx, right_nx;
   logic [EDGE_W-1:0] top_ff, bottom_ff, left_ff, right_ff;

   // Take register writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= SIZE_RESET;
         grid_cols_ff <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GRID_ROWS: grid_rows_ff <= csr_wdata;
            REG_GRID_COLS: grid_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Accept a word when the result register is empty or draining
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   mpbb_tracker #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .AW       (AW)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .action     (req_action),
      .cell_char  (req_cell_char),
      .grid_rows  (grid_rows_ff),
      .grid_cols  (grid_cols_ff),
      .mem_we     (mem_we),
      .mem_re     (mem_re),
      .mem_addr   (mem_addr),
      .status     (trk_status),
      .box_top    (top_nx),
      .box_bottom (bottom_nx),
      .box_left   (left_nx),
      .box_right  (right_nx)
   );

   mpbb_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (req_cell_char),
      .rd_data (mem_q)
   );

   // Result register: valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register: payload, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= trk_status;
         top_ff    <= top_nx;
         bottom_ff <= bottom_nx;
         left_ff   <= left_nx;
         right_ff  <= right_nx;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = status_ff.read_hit ? mem_q : '0;
   assign rsp_read_valid = status_ff.read_hit;
   assign rsp_row_end    = status_ff.row_end;
   assign rsp_crop_last  = status_ff.crop_last;
   assign rsp_frame_done = status_ff.frame_done;
   assign rsp_box_empty  = status_ff.box_empty;
   assign rsp_box_top    = top_ff;
   assign rsp_box_bottom = bottom_ff;
   assign rsp_box_left   = left_ff;
   assign rsp_box_right  = right_ff;

endmodule

### sim/testbench.sv
// Testbench for marked_pixel_bounding_box_crop_top: loads character grids, reads back
// the cropped box and checks every response word against an in-bench predictor.
// Depends on design/mpbb_pkg.sv and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
   import mpbb_pkg::*;

   localparam int GRID_MAX     = 64;
   localparam int GRID_AW      = $clog2(GRID_MAX * GRID_MAX);
   localparam int RANDOM_ITEMS = 1400;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              read_valid;
      logic              row_end;
      logic              crop_last;
      logic              frame_done;
      logic              box_empty;
      logic [EDGE_W-1:0] box_top;
      logic [EDGE_W-1:0] box_bottom;
      logic [EDGE_W-1:0] box_left;
      logic [EDGE_W-1:0] box_right;
   } crop_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_action = ACT_LOAD;
   logic [CHAR_W-1:0]    req_cell_char = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CHAR_W-1:0]    rsp_out_char;
   logic                 rsp_read_valid;
   logic                 rsp_row_end;
   logic                 rsp_crop_last;
   logic                 rsp_frame_done;
   logic                 rsp_box_empty;
   logic [EDGE_W-1:0]    rsp_box_top;
   logic [EDGE_W-1:0]    rsp_box_bottom;
   logic [EDGE_W-1:0]    rsp_box_left;
   logic [EDGE_W-1:0]    rsp_box_right;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_GRID_ROWS;
   logic [SIZE_W-1:0]    csr_wdata = '0;

   // Predictor state: grid copy, cursors, box and size registers
   logic [CHAR_W-1:0] grid_mem [0:GRID_MAX*GRID_MAX-1];
   bit                grid_written [0:GRID_MAX*GRID_MAX-1];
   logic [SIZE_W-1:0] size_rows = SIZE_RESET;
   logic [SIZE_W-1:0] size_cols = SIZE_RESET;
   int unsigned       ld_row, ld_col, rd_row, rd_col;
   int unsigned       box_t, box_b, box_l, box_r;
   bit                frame_full, any_mark;

   crop_word_type pending_crops [$];
   crop_word_type next_crop;
   int unsigned   fail_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   sent_total = 0;
   int unsigned   req_gap_pct = 0;
   int unsigned   rsp_stall_pct = 0;

   marked_pixel_bounding_box_crop_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_cell_char  (req_cell_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_read_valid (rsp_read_valid),
      .rsp_row_end    (rsp_row_end),
      .rsp_crop_last  (rsp_crop_last),
      .rsp_frame_done (rsp_frame_done),
      .rsp_box_empty  (rsp_box_empty),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_bottom (rsp_box_bottom),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_right  (rsp_box_right),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   // Count cycles and end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stall the response side at random
   always @(posedge clock) begin
      if (rsp_stall_pct != 0)
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      else
         rsp_stall <= 1'b0;
   end

   function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      return (v > GRID_MAX) ? GRID_MAX : int'(v);
   endfunction

   function automatic void clear_box();
      ld_row = 0; ld_col = 0; frame_full = 1'b0;
      box_t = int'(EDGE_CLEAR); box_b = 0; box_l = int'(EDGE_CLEAR); box_r = 0;
      any_mark = 1'b0;
      rd_row = 0; rd_col = 0;
   endfunction

   // Advance the crop state by one word and return the response it causes
   function automatic crop_word_type predict_crop(logic act, logic [CHAR_W-1:0] ch);
      crop_word_type      w;
      int unsigned        rows, cols, wm1, hm1;
      logic [GRID_AW-1:0] addr;
      w = '0;
      rows = clamp_size(size_rows);
      cols = clamp_size(size_cols);
      if (act == ACT_LOAD) begin
         if (frame_full) clear_box();
         addr = GRID_AW'(ld_row * GRID_MAX + ld_col);
         grid_mem[addr] = ch;
         grid_written[addr] = 1'b1;
         if (ch == MARK_CHAR) begin
            if (!any_mark) begin
               box_t = ld_row; box_b = ld_row; box_l = ld_col; box_r = ld_col;
               any_mark = 1'b1;
            end else begin
               if (ld_row < box_t) box_t = ld_row;
               if (ld_row > box_b) box_b = ld_row;
               if (ld_col < box_l) box_l = ld_col;
               if (ld_col > box_r) box_r = ld_col;
            end
         end
         if (ld_col + 1 >= cols) begin
            ld_col = 0;
            if (ld_row + 1 >= rows) begin
               ld_row = 0;
               frame_full = 1'b1;
            end else begin
               ld_row++;
            end
         end else begin
            ld_col++;
         end
      end else if (frame_full && any_mark) begin
         wm1 = box_r - box_l;
         hm1 = box_b - box_t;
         addr = GRID_AW'((box_t + rd_row) * GRID_MAX + box_l + rd_col);
         w.out_char = grid_mem[addr];
         w.read_valid = 1'b1;
         w.row_end = (rd_col >= wm1);
         w.crop_last = w.row_end && (rd_row >= hm1);
         if (w.row_end) begin
            rd_col = 0;
            rd_row = w.crop_last ? 0 : rd_row + 1;
         end else begin
            rd_col++;
         end
      end
      w.frame_done = frame_full;
      w.box_empty = !any_mark;
      w.box_top = box_t[EDGE_W-1:0];
      w.box_bottom = box_b[EDGE_W-1:0];
      w.box_left = box_l[EDGE_W-1:0];
      w.box_right = box_r[EDGE_W-1:0];
      return w;
   endfunction

   // A read must never touch a cell the grid store has not been given yet
   function automatic bit read_is_safe();
      if (!frame_full || !any_mark) return 1'b1;
      return grid_written[GRID_AW'((box_t + rd_row) * GRID_MAX + box_l + rd_col)];
   endfunction

   function automatic void check_field(string name, logic [7:0] expv, logic [7:0] actv);
      if (expv !== actv) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      end
   endfunction

   // Compare each accepted response word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_crops.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response word, expected none, actual %0d",
                     $time, rsp_out_char);
         end else begin
            next_crop = pending_crops.pop_front();
            check_field("out_char", next_crop.out_char, rsp_out_char);
            check_field("read_valid", 8'(next_crop.read_valid), 8'(rsp_read_valid));
            check_field("row_end", 8'(next_crop.row_end), 8'(rsp_row_end));
            check_field("crop_last", 8'(next_crop.crop_last), 8'(rsp_crop_last));
            check_field("frame_done", 8'(next_crop.frame_done), 8'(rsp_frame_done));
            check_field("box_empty", 8'(next_crop.box_empty), 8'(rsp_box_empty));
            check_field("box_top", 8'(next_crop.box_top), 8'(rsp_box_top));
            check_field("box_bottom", 8'(next_crop.box_bottom), 8'(rsp_box_bottom));
            check_field("box_left", 8'(next_crop.box_left), 8'(rsp_box_left));
            check_field("box_right", 8'(next_crop.box_right), 8'(rsp_box_right));
         end
      end
   end

   // Send one request word, with random gaps before it
   task automatic send_word(logic act, logic [CHAR_W-1:0] ch);
      crop_word_type exp_word;
      while (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_cell_char <= ch;
      do @(posedge clock); while (req_stall);
      exp_word = predict_crop(act, ch);
      pending_crops.insert(pending_crops.size(), exp_word);
      sent_total++;
   endtask

   // Drop valid and hold until every predicted word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_crops.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_GRID_ROWS) size_rows = val;
      else size_cols = val;
   endtask

   task automatic set_idle_phase(int unsigned phase);
      case (phase)
         0: begin
            req_gap_pct = 24; rsp_stall_pct = 50;
         end
         1: begin
            req_gap_pct = 50; rsp_stall_pct = 24;
         end
         default: begin
            req_gap_pct = 0; rsp_stall_pct = 0;
         end
      endcase
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 8) return SIZE_W'($urandom_range(65, 127));
      if (r < 14) return SIZE_W'(GRID_MAX);
      return SIZE_W'($urandom_range(1, 8));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char(int unsigned mark_pct);
      if ($urandom_range(0, 99) < mark_pct) return MARK_CHAR;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // Load a full frame of plain bytes, marked in the top-right and bottom-left cells
   task automatic load_corner_frame(int unsigned n_rows, int unsigned n_cols);
      logic [CHAR_W-1:0] ch;
      for (int unsigned r = 0; r < n_rows; r++) begin
         for (int unsigned c = 0; c < n_cols; c++) begin
            ch = CHAR_W'($urandom_range(0, 255));
            if (ch == MARK_CHAR) ch = ch + 8'd1;
            if ((r == 0 && c == n_cols - 1) || (r == n_rows - 1 && c == 0))
               ch = MARK_CHAR;
            send_word(ACT_LOAD, ch);
         end
      end
   endtask

   // Read before any frame is complete: no data, cleared box
   task automatic test_idle_read();
      send_word(ACT_READ, 8'hFF);
      wait_drained();
   endtask

   // Zero sizes count as one: a 1 x 1 grid, marked then unmarked
   task automatic test_single_cell();
      write_csr(REG_GRID_ROWS, '0);
      write_csr(REG_GRID_COLS, '0);
      send_word(ACT_LOAD, MARK_CHAR);
      send_word(ACT_READ, 8'h00);
      send_word(ACT_READ, 8'h5A);
      send_word(ACT_LOAD, 8'h00);
      send_word(ACT_READ, 8'hA5);
      wait_drained();
   endtask

   // 2 x 3 grid: first mark sets all edges, a read mid-frame gives no data,
   // the box is read past its last byte so the cursor wraps
   task automatic test_small_box();
      write_csr(REG_GRID_ROWS, 7'd2);
      write_csr(REG_GRID_COLS, 7'd3);
      send_word(ACT_LOAD, 8'h61);
      send_word(ACT_LOAD, 8'hFF);
      send_word(ACT_LOAD, MARK_CHAR);
      send_word(ACT_READ, 8'h00);
      send_word(ACT_LOAD, MARK_CHAR);
      send_word(ACT_LOAD, 8'h00);
      send_word(ACT_LOAD, 8'h62);
      repeat (7) send_word(ACT_READ, CHAR_W'($urandom_range(0, 255)));
      wait_drained();
   endtask

   // Column count shrinks while a frame is half loaded
   task automatic test_midframe_resize();
      write_csr(REG_GRID_ROWS, 7'd2);
      write_csr(REG_GRID_COLS, 7'd4);
      send_word(ACT_LOAD, 8'h78);
      send_word(ACT_LOAD, MARK_CHAR);
      send_word(ACT_LOAD, 8'h79);
      write_csr(REG_GRID_COLS, 7'd2);
      send_word(ACT_LOAD, 8'h7A);
      send_word(ACT_LOAD, MARK_CHAR);
      send_word(ACT_LOAD, 8'h77);
      repeat (4) begin
         if (read_is_safe()) send_word(ACT_READ, 8'h00);
      end
      wait_drained();
   endtask

   // Sizes above the maximum clamp to 64, rows first and then columns
   task automatic test_size_clamp();
      write_csr(REG_GRID_ROWS, 7'd127);
      write_csr(REG_GRID_COLS, 7'd2);
      load_corner_frame(GRID_MAX, 2);
      repeat (40) send_word(ACT_READ, CHAR_W'($urandom_range(0, 255)));
      write_csr(REG_GRID_ROWS, 7'd2);
      write_csr(REG_GRID_COLS, 7'd65);
      load_corner_frame(2, GRID_MAX);
      repeat (70) send_word(ACT_READ, CHAR_W'($urandom_range(0, 255)));
      wait_drained();
   endtask

   // Random frames: full loads with random content, read bursts, noise reads,
   // occasional resizes between and inside frames
   task automatic test_random_frames();
      int unsigned counted, mark_pct, area, n_reads;
      logic [SIZE_W-1:0] new_rows, new_cols;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         set_idle_phase(counted * 3 / RANDOM_ITEMS);
         if ($urandom_range(0, 99) < 35) begin
            new_rows = pick_size();
            new_cols = pick_size();
            if (clamp_size(new_rows) * clamp_size(new_cols) > 512)
               new_cols = SIZE_W'($urandom_range(1, 4));
            write_csr(REG_GRID_ROWS, new_rows);
            write_csr(REG_GRID_COLS, new_cols);
         end
         if ($urandom_range(0, 99) < 4) wait_drained();
         case ($urandom_range(0, 3))
            0: mark_pct = 0;
            1: mark_pct = 3;
            2: mark_pct = 15;
            default: mark_pct = 50;
         endcase
         // Load one frame, with stray reads and rare resizes mixed in
         send_word(ACT_LOAD, pick_char(mark_pct));
         counted++;
         while (!frame_full) begin
            if ($urandom_range(0, 99) < 5) begin
               send_word(ACT_READ, CHAR_W'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 99) < 2) begin
               write_csr($urandom_range(0, 1) ? REG_GRID_COLS : REG_GRID_ROWS,
                         SIZE_W'($urandom_range(1, 8)));
            end else begin
               send_word(ACT_LOAD, pick_char(mark_pct));
               counted++;
            end
         end
         // Read the box, sometimes past its end to wrap
         area = any_mark ? (box_b - box_t + 1) * (box_r - box_l + 1) : 0;
         n_reads = $urandom_range(0, area * 2 + 1);
         if (n_reads > 60) n_reads = 60;
         for (int i = 0; i < n_reads; i++) begin
            if (!read_is_safe()) break;
            send_word(ACT_READ, CHAR_W'($urandom_range(0, 255)));
            if (any_mark) counted++;
         end
      end
      set_idle_phase(2);
   endtask

   initial begin
      clear_box();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idle_phase(0);
      test_idle_read();
      test_single_cell();
      test_small_box();
      test_midframe_resize();
      test_size_clamp();
      test_random_frames();
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_crops.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
design/mpbb_pkg.sv
design/mpbb_store.sv
design/mpbb_tracker.sv
design/marked_pixel_bounding_box_crop_top.sv
sim/testbench.sv
